// ===== hdl/dd_pkg.sv =====
// Shared constants, tables and types for the date difference block.
// No dependencies; imported by dd_day_number and date_difference_in_days.
`default_nettype none

package dd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int COUNT_W   = 22;
    localparam int DN_W      = 23;     // day number of any 14-bit year fits
    localparam int LEAPS_W   = 13;
    localparam int MB_W      = 9;      // days before a month, up to 334
    localparam int PROD_W    = 28;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
    localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
    localparam logic [DAY_W-1:0]   FEB_DAYS  = 5'd28;

    // floor(x / 100) == (x * RECIP100) >> 19 for x below 43690
    localparam logic [12:0] RECIP100   = 13'd5243;
    localparam int          RECIP_SHR  = 19;
    localparam logic [7:0]  CENTURY    = 8'd100;

    // Stage advance strobes, one per pipeline stage of a day number unit
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } dd_adv_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [MB_W-1:0] month_before(input logic [MONTH_W-1:0] m);
        logic [MB_W-1:0] mb;
        case (m)
            4'd1:    mb = 9'd0;
            4'd2:    mb = 9'd31;
            4'd3:    mb = 9'd59;
            4'd4:    mb = 9'd90;
            4'd5:    mb = 9'd120;
            4'd6:    mb = 9'd151;
            4'd7:    mb = 9'd181;
            4'd8:    mb = 9'd212;
            4'd9:    mb = 9'd243;
            4'd10:   mb = 9'd273;
            4'd11:   mb = 9'd304;
            4'd12:   mb = 9'd334;
            default: mb = 9'd0;
        endcase
        return mb;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/date_difference_in_days.sv =====
// Gregorian day difference, top level: four-stage pipeline around two
// day number units. Depends on dd_pkg and dd_day_number.
`default_nettype none

// Usage
//   Input channel: in_valid / in_stall carry one item, a pair of dates
//   (year, month, day each) plus include_end. An item is taken at a clock
//   edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall carry day_count and date_error.
//   day_count = end day number - start day number when positive, else 0,
//   plus include_end. date_error flags a bad year, month or day in either
//   date; day_count is then 0.
// Timing
//   Four register stages: an accepted item passes through stages 1, 2, 3 and 4
//   in that order, and out_valid rises when the item reaches stage 4.
//   One item per cycle is sustained while out_stall is low; that figure is set
//   by the stage registers, the deepest of which holds the constant-reciprocal
//   multiplies of stage 1.
// Reset
//   rst_n clears all stage valid bits; no item is in flight after reset.
// Stall
//   When out_stall holds a result, earlier stages keep filling any bubbles
//   and in_stall rises only once all four stages hold items. Nothing is
//   dropped or repeated.
module date_difference_in_days
    import dd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    input  wire logic               include_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COUNT_W-1:0]      day_count,
    output logic                    date_error
);

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;
    dd_adv_t adv;

    // a stage loads when empty or when its contents move on
    assign ld4 = !v4_reg || !out_stall;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_stall = !ld1;

    assign adv.s1 = ld1;
    assign adv.s2 = ld2;
    assign adv.s3 = ld3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
            if (ld4)
                v4_reg <= v3_reg;
        end
    end

    // include_end rides along with its item
    logic inc1_reg, inc2_reg, inc3_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
            inc1_reg <= include_end;
        if (ld2)
            inc2_reg <= inc1_reg;
        if (ld3)
            inc3_reg <= inc2_reg;
    end

    // day numbers of both dates, valid after stage 3
    logic [DN_W-1:0] dn_start, dn_end;
    logic            ok_start, ok_end;

    dd_day_number u_start
    (
        .clk     (clk),
        .adv     (adv),
        .year    (start_year),
        .month   (start_month),
        .day     (start_day),
        .day_num (dn_start),
        .date_ok (ok_start)
    );

    dd_day_number u_end
    (
        .clk     (clk),
        .adv     (adv),
        .year    (end_year),
        .month   (end_month),
        .day     (end_day),
        .day_num (dn_end),
        .date_ok (ok_end)
    );

    // stage 4: difference, end-day add, saturation, error
    logic [DN_W:0]        diff;
    logic [COUNT_W-1:0]   count_next, count_reg;
    logic                 err_next, err_reg;

    always_comb
    begin
        diff = (dn_start < dn_end) ? ({1'b0, dn_end} - {1'b0, dn_start}) : '0;
        diff = diff + (DN_W+1)'(inc3_reg);
        err_next = !(ok_start && ok_end);
        if (err_next)
            count_next = '0;
        else if (diff > (DN_W+1)'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = diff[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid  = v4_reg;
    assign day_count  = count_reg;
    assign date_error = err_reg;

`ifndef SYNTH
    // an invalid date never reports a count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && date_error) |-> (day_count == '0))
        else $error("date_error with nonzero day_count");

    // input backs up only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with a bubble in the pipeline");

    // a held output stage keeps stage 3 from being lost
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && out_stall) |=> (v3_reg && v4_reg))
        else $error("item lost under output stall");
`endif

endmodule

`default_nettype wire

// ===== hdl/dd_day_number.sv =====
// Three-stage day number unit: one date in, day number since 1 Jan year 0 out.
// Depends on dd_pkg. Stage loads are driven by the top level's advance strobes.
`default_nettype none

module dd_day_number
    import dd_pkg::*;
(
    input  wire logic               clk,
    input  wire dd_adv_t            adv,
    input  wire logic [YEAR_W-1:0]  year,
    input  wire logic [MONTH_W-1:0] month,
    input  wire logic [DAY_W-1:0]   day,
    output logic [DN_W-1:0]         day_num,
    output logic                    date_ok
);

    // stage 1: products, quotient by 4, table lookups
    logic [PROD_W-1:0]  p99_reg, p399_reg, py_reg;
    logic [PROD_W-1:0]  p99_next, p399_next, py_next;
    logic [LEAPS_W-1:0] q4_reg, q4_next;
    logic [DN_W-1:0]    y365_reg, y365_next;
    logic [MB_W-1:0]    mb1_reg, mb1_next;
    logic [DAY_W-1:0]   len1_reg, len1_next;
    logic [DAY_W-1:0]   day1_reg;
    logic [YEAR_W-1:0]  year1_reg;
    logic               feb1_reg, late1_reg, fmt1_reg, div4_reg;
    logic               feb1_next, late1_next, fmt1_next, div4_next;

    always_comb
    begin
        p99_next   = PROD_W'({1'b0, year} + 15'd99) * PROD_W'(RECIP100);
        p399_next  = PROD_W'({1'b0, year} + 15'd399) * PROD_W'(RECIP100);
        py_next    = PROD_W'(year) * PROD_W'(RECIP100);
        q4_next    = LEAPS_W'(({1'b0, year} + 15'd3) >> 2);
        y365_next  = DN_W'(year) * DN_W'(365);
        mb1_next   = month_before(month);
        len1_next  = month_len(month);
        feb1_next  = (month == FEBRUARY);
        late1_next = (month > FEBRUARY);
        fmt1_next  = (year <= MAX_YEAR) && (month != '0) && (month <= MONTHS)
                     && (day != '0);
        div4_next  = (year[1:0] == 2'b00);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            p99_reg   <= p99_next;
            p399_reg  <= p399_next;
            py_reg    <= py_next;
            q4_reg    <= q4_next;
            y365_reg  <= y365_next;
            mb1_reg   <= mb1_next;
            len1_reg  <= len1_next;
            day1_reg  <= day;
            year1_reg <= year;
            feb1_reg  <= feb1_next;
            late1_reg <= late1_next;
            fmt1_reg  <= fmt1_next;
            div4_reg  <= div4_next;
        end
    end

    // stage 2: leap rule, validity, leap count, partial sum
    logic [7:0]         q100, qy;
    logic [5:0]         q400;
    logic               cent, leap;
    logic [DAY_W-1:0]   len;
    logic [LEAPS_W-1:0] leaps_reg, leaps_next;
    logic [DN_W-1:0]    part_reg, part_next;
    logic               adj_reg, adj_next;
    logic               ok2_reg, ok2_next;

    always_comb
    begin
        q100       = p99_reg[RECIP_SHR+7:RECIP_SHR];
        q400       = p399_reg[RECIP_SHR+7:RECIP_SHR+2];
        qy         = py_reg[RECIP_SHR+7:RECIP_SHR];
        cent       = ((YEAR_W'(qy) * YEAR_W'(CENTURY)) == year1_reg);
        leap       = div4_reg && (!cent || (qy[1:0] == 2'b00));
        len        = feb1_reg ? (FEB_DAYS + DAY_W'(leap)) : len1_reg;
        ok2_next   = fmt1_reg && (day1_reg <= len);
        adj_next   = late1_reg && leap;
        leaps_next = q4_reg - LEAPS_W'(q100) + LEAPS_W'(q400);
        part_next  = y365_reg + DN_W'(mb1_reg) + DN_W'(day1_reg - 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            leaps_reg <= leaps_next;
            part_reg  <= part_next;
            adj_reg   <= adj_next;
            ok2_reg   <= ok2_next;
        end
    end

    // stage 3: final day number
    logic [DN_W-1:0] dn_reg, dn_next;
    logic            ok3_reg;

    assign dn_next = part_reg + DN_W'(leaps_reg) + DN_W'(adj_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            dn_reg  <= dn_next;
            ok3_reg <= ok2_reg;
        end
    end

    assign day_num = dn_reg;
    assign date_ok = ok3_reg;

endmodule

`default_nettype wire
